@@ hw/rtl/scba_pkg.sv @@
// shared types and constants of the size class bitmap allocator
package scba_pkg;

    localparam int unsigned SIZE_W   = 14;
    localparam int unsigned CLASS_W  = 4;
    localparam int unsigned SLOT_W   = 9;
    localparam int unsigned OFFSET_W = 23;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned MAX_REQUEST_BYTES = 8192;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SLOT  = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        JOB_ALLOC,
        JOB_FREE,
        JOB_REJECT
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        t_status             status;
        logic [CLASS_W-1:0]  cls;
        logic [SLOT_W-1:0]   slot;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EVAL,
        BK_DONE
    } t_bk_state;

endpackage

@@ hw/rtl/scba_front.sv @@
// request classification: size check, first fitting class, free range check
module scba_front import scba_pkg::*; #(
    parameter int unsigned NUM_CLASSES     = 13,
    parameter int unsigned SLOTS_PER_CLASS = 512,
    parameter int unsigned MIN_CHUNK_BYTES = 4
) (
    input  t_cmd               i_cmd,
    input  logic [SIZE_W-1:0]  i_request_size,
    input  logic [CLASS_W-1:0] i_free_class,
    input  logic [SLOT_W-1:0]  i_free_slot,
    output t_job               o_job
);

    logic                first_found;
    logic [CLASS_W-1:0]  first_class;

    // smallest class whose chunk holds the size
    always_comb begin
        first_found = 1'b0;
        first_class = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if ((32'(MIN_CHUNK_BYTES) << c) >= 32'(i_request_size)) begin
                first_found = 1'b1;
                first_class = CLASS_W'(c);
            end
        end
    end

    always_comb begin
        o_job.kind   = JOB_REJECT;
        o_job.status = ST_OK;
        o_job.cls    = '0;
        o_job.slot   = '0;
        unique case (i_cmd)
            CMD_FREE: begin
                if (32'(i_free_class) >= 32'(NUM_CLASSES) ||
                    32'(i_free_slot) >= 32'(SLOTS_PER_CLASS)) begin
                    o_job.status = ST_BAD_FREE;
                end else begin
                    o_job.kind = JOB_FREE;
                    o_job.cls  = i_free_class;
                    o_job.slot = i_free_slot;
                end
            end
            default: begin
                if (i_request_size == '0 ||
                    32'(i_request_size) > 32'(MAX_REQUEST_BYTES)) begin
                    o_job.status = ST_BAD_SIZE;
                end else if (!first_found) begin
                    o_job.status = ST_NO_SLOT;
                end else begin
                    o_job.kind = JOB_ALLOC;
                    o_job.cls  = first_class;
                end
            end
        endcase
    end

endmodule

@@ hw/rtl/scba_queue.sv @@
// short job queue between the classifier and the bitmap engine
module scba_queue import scba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    t_job                r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wp, n_wp;
    logic [PTR_W-1:0]    r_rp, n_rp;
    logic [PTR_W:0]      r_cnt, n_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_entry[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wp] <= i_job;
        end
    end

endmodule

@@ hw/rtl/scba_back.sv @@
// bitmap engine: word scan, bit set and clear, result register
module scba_back import scba_pkg::*; #(
    parameter int unsigned NUM_CLASSES     = 13,
    parameter int unsigned WORDS_PER_CLASS = 16,
    parameter int unsigned WORD_BITS       = 32,
    parameter int unsigned MIN_CHUNK_BYTES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  t_job                i_job,
    output logic                o_job_pop,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output t_status             o_status,
    output logic [CLASS_W-1:0]  o_class,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [OFFSET_W-1:0] o_offset
);

    localparam int unsigned DEPTH = NUM_CLASSES * WORDS_PER_CLASS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned WW    = (WORDS_PER_CLASS > 1) ? $clog2(WORDS_PER_CLASS) : 1;
    localparam int unsigned BW    = $clog2(WORD_BITS);
    localparam int unsigned SW    = WW + BW;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]     r_wvalid;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvalid;

    t_bk_state            r_state, n_state;
    t_kind                r_kind, n_kind;
    logic [CLASS_W-1:0]   r_cls, n_cls;
    logic [WW-1:0]        r_word, n_word;
    logic [AW-1:0]        r_addr, n_addr;
    logic [BW-1:0]        r_bit, n_bit;
    logic [SW-1:0]        r_slot, n_slot;
    t_status              r_status, n_status;
    logic                 r_grant, n_grant;

    logic                 r_ovalid;
    t_status              r_ostatus;
    logic [CLASS_W-1:0]   r_oclass;
    logic [SLOT_W-1:0]    r_oslot;
    logic [OFFSET_W-1:0]  r_ooffset;

    logic [WORD_BITS-1:0] cur_word;
    logic [BW-1:0]        clear_bit;
    logic                 word_full;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 out_load;
    logic [63:0]          offset_wide;

    // words never written read as all free
    assign cur_word  = r_rvalid ? r_rdata : '0;
    assign word_full = &cur_word;

    always_comb begin
        clear_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!cur_word[b]) begin
                clear_bit = BW'(b);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.kind == JOB_REJECT) ? BK_DONE : BK_READ;
                end
            end
            BK_READ: n_state = BK_EVAL;
            BK_EVAL: begin
                if (r_kind == JOB_FREE || !word_full) begin
                    n_state = BK_DONE;
                end else if (r_word == WW'(WORDS_PER_CLASS - 1) &&
                             r_cls == CLASS_W'(NUM_CLASSES - 1)) begin
                    n_state = BK_DONE;
                end else begin
                    n_state = BK_READ;
                end
            end
            BK_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_kind    = r_kind;
        n_cls     = r_cls;
        n_word    = r_word;
        n_addr    = r_addr;
        n_bit     = r_bit;
        n_slot    = r_slot;
        n_status  = r_status;
        n_grant   = r_grant;
        o_job_pop = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = cur_word;
        out_load  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_kind    = i_job.kind;
                    n_cls     = i_job.cls;
                    n_status  = i_job.status;
                    n_grant   = 1'b0;
                    n_slot    = '0;
                    n_bit     = i_job.slot[BW-1:0];
                    if (i_job.kind == JOB_FREE) begin
                        n_addr = AW'(32'(i_job.cls) * WORDS_PER_CLASS
                                     + (32'(i_job.slot) >> BW));
                    end else begin
                        n_word = '0;
                        n_addr = AW'(32'(i_job.cls) * WORDS_PER_CLASS);
                    end
                end
            end
            BK_EVAL: begin
                if (r_kind == JOB_FREE) begin
                    mem_we    = 1'b1;
                    mem_wdata = cur_word & ~(WORD_BITS'(1) << r_bit);
                    n_status  = ST_OK;
                end else if (!word_full) begin
                    mem_we    = 1'b1;
                    mem_wdata = cur_word | (WORD_BITS'(1) << clear_bit);
                    n_status  = ST_OK;
                    n_grant   = 1'b1;
                    n_slot    = {r_word, clear_bit};
                end else if (r_word == WW'(WORDS_PER_CLASS - 1)) begin
                    if (r_cls == CLASS_W'(NUM_CLASSES - 1)) begin
                        n_status = ST_NO_SLOT;
                    end else begin
                        n_cls  = r_cls + 1'b1;
                        n_word = '0;
                        n_addr = r_addr + 1'b1;
                    end
                end else begin
                    n_word = r_word + 1'b1;
                    n_addr = r_addr + 1'b1;
                end
            end
            BK_DONE: begin
                out_load = !r_ovalid || i_out_ready;
            end
            default: ;
        endcase
    end

    // chunk size of class c is the minimum chunk shifted by c
    assign offset_wide = (64'(r_slot) * 64'(MIN_CHUNK_BYTES)) << r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_wvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_wvalid[r_addr] <= 1'b1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rdata  <= r_mem[r_addr];
        r_rvalid <= r_wvalid[r_addr];
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_cls    <= n_cls;
        r_word   <= n_word;
        r_addr   <= n_addr;
        r_bit    <= n_bit;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_grant  <= n_grant;
        if (out_load) begin
            r_ostatus <= r_status;
            r_oclass  <= r_grant ? r_cls : '0;
            r_oslot   <= r_grant ? SLOT_W'(r_slot) : '0;
            r_ooffset <= r_grant ? offset_wide[OFFSET_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_class     = r_oclass;
    assign o_slot      = r_oslot;
    assign o_offset    = r_ooffset;

endmodule

@@ hw/rtl/size_class_bitmap_allocator.sv @@
// Slot allocator with power-of-two size classes and one occupancy bitmap per class.
// An allocate beat (tuser 0) asks for a size of 1 to 8192 bytes; the smallest fitting
// class is searched word by word for the lowest free slot, moving on to larger classes
// when full. A free beat (tuser 1) clears one slot. Every request gives exactly one
// result beat carrying a status in tuser and class, slot and byte offset in tdata.
// A rejected request skips the bitmap; a free reads one word, then clears the bit;
// an allocate reads and then examines one bitmap word at a time, since the bitmap
// memory has one port. The bitmap needs no clearing pass: a valid flag per word
// makes unwritten words read as free. WORD_BITS must be a power of two. Requests
// queue in front of the engine, so input beats are taken while a search runs, as long
// as the queue has room, and a finished result waits in an output register.
module size_class_bitmap_allocator import scba_pkg::*; #(
    parameter int unsigned NUM_CLASSES     = 13,
    parameter int unsigned WORDS_PER_CLASS = 16,
    parameter int unsigned WORD_BITS       = 32,
    parameter int unsigned MIN_CHUNK_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // request_size[13:0], free_class[17:14], free_slot[26:18]
    input  logic        s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // granted_class[3:0], granted_slot[12:4], byte_offset[35:13]
    output logic [1:0]  m_axis_tuser   // status
);

    t_job                q_in_job;
    t_job                q_out_job;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    t_status             res_status;
    logic [CLASS_W-1:0]  res_class;
    logic [SLOT_W-1:0]   res_slot;
    logic [OFFSET_W-1:0] res_offset;

    assign s_axis_tready = !q_full;

    scba_front #(
        .NUM_CLASSES     (NUM_CLASSES),
        .SLOTS_PER_CLASS (WORDS_PER_CLASS * WORD_BITS),
        .MIN_CHUNK_BYTES (MIN_CHUNK_BYTES)
    ) u_front (
        .i_cmd          (t_cmd'(s_axis_tuser)),
        .i_request_size (s_axis_tdata[13:0]),
        .i_free_class   (s_axis_tdata[17:14]),
        .i_free_slot    (s_axis_tdata[26:18]),
        .o_job          (q_in_job)
    );

    scba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid && !q_full),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    scba_back #(
        .NUM_CLASSES     (NUM_CLASSES),
        .WORDS_PER_CLASS (WORDS_PER_CLASS),
        .WORD_BITS       (WORD_BITS),
        .MIN_CHUNK_BYTES (MIN_CHUNK_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_out_job),
        .o_job_pop   (q_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (res_status),
        .o_class     (res_class),
        .o_slot      (res_slot),
        .o_offset    (res_offset)
    );

    assign m_axis_tuser = res_status;
    assign m_axis_tdata = {4'b0, res_offset, res_slot, res_class};

endmodule

@@ test/size_class_bitmap_allocator_tb.sv @@
// testbench for the size class bitmap allocator: random and directed requests checked against a local model
`timescale 1ns / 100ps

class alloc_scoreboard;
    logic [31:0] occ [13*16];
    logic [1:0]  exp_status [$];
    logic [3:0]  exp_class [$];
    logic [8:0]  exp_slot [$];
    logic [22:0] exp_offset [$];
    int          n_errors;
    int          n_done;

    function new();
        foreach (occ[i]) occ[i] = '0;
        n_errors = 0;
        n_done = 0;
    endfunction

    function void push(logic [1:0] st, logic [3:0] c, logic [8:0] s, logic [22:0] o);
        exp_status.push_back(st);
        exp_class.push_back(c);
        exp_slot.push_back(s);
        exp_offset.push_back(o);
    endfunction

    // predict the result of one accepted request and update the bitmap
    function void note_request(scba_pkg::t_cmd cmd, logic [13:0] size, logic [3:0] fcls,
                               logic [8:0] fslot);
        int first;
        logic [8:0] slot;
        if (cmd == scba_pkg::CMD_FREE) begin
            if (fcls >= 13) begin
                push(scba_pkg::ST_BAD_FREE, 4'd0, 9'd0, 23'd0);
            end else begin
                occ[fcls*16 + fslot/32][fslot%32] = 1'b0;
                push(scba_pkg::ST_OK, 4'd0, 9'd0, 23'd0);
            end
            return;
        end
        if (size == 0 || size > scba_pkg::MAX_REQUEST_BYTES) begin
            push(scba_pkg::ST_BAD_SIZE, 4'd0, 9'd0, 23'd0);
            return;
        end
        first = 13;
        for (int c = 0; c < 13; c++)
            if ((4 << c) >= size) begin
                first = c;
                break;
            end
        for (int c = first; c < 13; c++)
            for (int w = 0; w < 16; w++)
                if (occ[c*16+w] != '1)
                    for (int b = 0; b < 32; b++)
                        if (!occ[c*16+w][b]) begin
                            occ[c*16+w][b] = 1'b1;
                            slot = 9'(w*32 + b);
                            push(scba_pkg::ST_OK, 4'(c), slot, 23'(slot * (4 << c)));
                            return;
                        end
        push(scba_pkg::ST_NO_SLOT, 4'd0, 9'd0, 23'd0);
    endfunction

    function void check_result(logic [1:0] st, logic [39:0] d);
        logic [1:0] es;
        logic [3:0] ec;
        logic [8:0] esl;
        logic [22:0] eo;
        n_done++;
        if (exp_status.size() == 0) begin
            $display("%0t: unexpected result beat status %0d data %h", $time, st, d);
            n_errors++;
            return;
        end
        es = exp_status.pop_front();
        ec = exp_class.pop_front();
        esl = exp_slot.pop_front();
        eo = exp_offset.pop_front();
        if (st !== es) begin
            $display("%0t: status expected %0d actual %0d", $time, es, st);
            n_errors++;
        end
        if (d[3:0] !== ec) begin
            $display("%0t: class expected %0d actual %0d", $time, ec, d[3:0]);
            n_errors++;
        end
        if (d[12:4] !== esl) begin
            $display("%0t: slot expected %0d actual %0d", $time, esl, d[12:4]);
            n_errors++;
        end
        if (d[35:13] !== eo) begin
            $display("%0t: offset expected %0d actual %0d", $time, eo, d[35:13]);
            n_errors++;
        end
    endfunction

    function int pending();
        return exp_status.size();
    endfunction
endclass

module size_class_bitmap_allocator_tb;
    import scba_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // request_size[13:0], free_class[17:14], free_slot[26:18]
    logic        s_axis_tuser = 1'b0;  // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;  // granted_class[3:0], granted_slot[12:4], byte_offset[35:13]
    logic [1:0]  m_axis_tuser;  // status

    alloc_scoreboard sb = new();
    int gap_left = 0;
    int burst_left = 0;
    bit stall_mode = 0;

    size_class_bitmap_allocator u_top (.*);

    always #5 i_clk = ~i_clk;

    // receiver stalls on its own pattern: phases of free running and of random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
        if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
        m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // send one beat in bursts with random gaps; returns once accepted
    task automatic send_request(t_cmd cmd, logic [13:0] size, logic [3:0] fcls, logic [8:0] fslot);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0) s_axis_tvalid <= 1'b0;
        while (gap_left > 0) begin
            @(posedge i_clk);
            gap_left--;
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {5'b0, fslot, fcls, size};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(cmd, size, fcls, fslot);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic alloc(logic [13:0] size);
        send_request(CMD_ALLOC, size, 4'($urandom), 9'($urandom));
    endtask

    task automatic free_slot(logic [3:0] c, logic [8:0] s);
        send_request(CMD_FREE, 14'($urandom), c, s);
    endtask

    // mostly small sizes so the lower classes fill and spill upward, with some larger, oversized and zero sizes
    function automatic logic [13:0] pick_size();
        int r = $urandom_range(0, 99);
        if (r < 60) return 14'($urandom_range(1, 16));
        if (r < 85) return 14'($urandom_range(1, 8192));
        if (r < 93) return 14'($urandom_range(8193, 16383));
        if (r < 96) return 14'd0;
        return 14'd8192;
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of size, the class boundaries at 4 and 4096 bytes, frees of all kinds
        alloc(0);
        alloc(1);
        alloc(4);
        alloc(5);
        alloc(8192);
        alloc(8193);
        alloc(14'h3fff);
        alloc(4096);
        alloc(4097);
        free_slot(0, 0);
        free_slot(0, 0);
        free_slot(12, 511);
        free_slot(13, 0);
        free_slot(15, 9'h1ff);
        free_slot(1, 9'h1ff);
        free_slot(11, 0);
        alloc(2);
        alloc(16);
        alloc(3000);

        drain();

        for (int i = 0; i < 1450; i++) begin
            int r = $urandom_range(0, 99);
            if (i == 700) drain();
            if (i >= 300 && i < 700) begin
                // fill classes 0 and 1 to drive spill-over into larger classes
                if (r < 90) alloc(14'($urandom_range(1, 8)));
                else free_slot(4'($urandom_range(0, 1)), 9'($urandom_range(0, 511)));
            end else if (r < 55) begin
                alloc(pick_size());
            end else if (r < 92) begin
                free_slot(4'($urandom_range(0, 12)), 9'($urandom_range(0, 511)));
            end else begin
                free_slot(4'($urandom), 9'($urandom));
            end
        end
        // a run of the largest legal size
        for (int i = 0; i < 40; i++) alloc(8192);

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #30ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
